// ===== hw/rtl/bcgd_pkg.sv =====
// Shared types, register indexes, reset values and result codes for the
// button click gesture detector. Depends on nothing.
package bcgd_pkg;

  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CODE_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 3'd4;

  // Reset values of the timing windows.
  localparam logic [WIN_W-1:0] BOUNCE_MS_RST       = 16'd50;
  localparam logic [WIN_W-1:0] DOUBLE_CLICK_MS_RST = 16'd300;
  localparam logic [WIN_W-1:0] LONG_PRESS_MS_RST   = 16'd1000;

  // Change codes.
  localparam logic [CODE_W-1:0] CHG_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] CHG_PRESSED  = 2'd1;
  localparam logic [CODE_W-1:0] CHG_RELEASED = 2'd2;

  // Action codes.
  localparam logic [CODE_W-1:0] ACT_NONE         = 2'd0;
  localparam logic [CODE_W-1:0] ACT_LONG_PRESS   = 2'd1;
  localparam logic [CODE_W-1:0] ACT_CLICK        = 2'd2;
  localparam logic [CODE_W-1:0] ACT_DOUBLE_CLICK = 2'd3;

  // Item kinds.
  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  typedef struct packed {
    logic             enabled;
    logic             active_high;
    logic [WIN_W-1:0] bounce_ms;
    logic [WIN_W-1:0] double_click_ms;
    logic [WIN_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              level_pressed;
    logic [CODE_W-1:0] change_code;
    logic [CODE_W-1:0] action_code;
  } result_t;

endpackage

// ===== hw/rtl/button_click_gesture_detector.sv =====
// Top level of the button click gesture detector: input register, result
// register and handshake. Depends on bcgd_pkg, bcgd_cfg and bcgd_core.
//
//   Port group  Direction  Beat contents
//   in_*        sink       kind, pin_level, now_ms (valid/stall)
//   out_*       source     level_pressed, change_code, action_code (valid/stall)
//   cfg_*       sink       write enable, register index, 16-bit write data
//
// One beat enters per cycle while in_stall is low. A beat is held in the
// input register, then its result, set by the combinational compare-and-update
// logic, goes into the result register as the gesture state updates.
// Reset is synchronous and active low; it empties both registers and
// restores the registers and the gesture state. A stall on the output holds
// the result and backs up into in_stall once the input register is full.
module button_click_gesture_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic                           in_pin_level,
  input  logic [bcgd_pkg::TIME_W-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_level_pressed,
  output logic [bcgd_pkg::CODE_W-1:0]     out_change_code,
  output logic [bcgd_pkg::CODE_W-1:0]     out_action_code,
  input  logic                           cfg_we,
  input  logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcgd_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    out_free;
  logic    step;
  logic    in_take;

  bcgd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcgd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Pipeline advance: the result register frees when empty or when taken.
  assign out_free = !res_vld_r || !out_stall;
  assign step     = item_vld_r && out_free;
  assign in_stall = item_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (step) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind      <= in_kind;
      item_r.pin_level <= in_pin_level;
      item_r.now_ms    <= in_now_ms;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (out_free) begin
      res_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_level_pressed = res_r.level_pressed;
  assign out_change_code   = res_r.change_code;
  assign out_action_code   = res_r.action_code;

  // The change code has no value beyond the defined change codes.
  a_change_code_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_code == CHG_NONE || out_change_code == CHG_PRESSED ||
                   out_change_code == CHG_RELEASED))
    else $error("change code out of range");

  // An action is only reported together with a change.
  a_action_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action_code != ACT_NONE) |-> (out_change_code != CHG_NONE))
    else $error("action without change");

  // A long press is only ever reported while the button is held down.
  a_long_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action_code == ACT_LONG_PRESS) |-> (out_change_code == CHG_PRESSED))
    else $error("long press reported on release");

  // Results are only produced from an item held in the input register.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(item_vld_r))
    else $error("result without item");

endmodule

// ===== hw/rtl/bcgd_cfg.sv =====
// Configuration register file of the button click gesture detector.
// Depends on bcgd_pkg for the register indexes, reset values and cfg_t.
module bcgd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcgd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bcgd_pkg::cfg_t                 cfg
);
  import bcgd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index beyond the list leaves every register alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:         cfg_nxt.enabled         = cfg_wdata[0];
        REG_ACTIVE_HIGH:     cfg_nxt.active_high     = cfg_wdata[0];
        REG_BOUNCE_MS:       cfg_nxt.bounce_ms       = cfg_wdata[WIN_W-1:0];
        REG_DOUBLE_CLICK_MS: cfg_nxt.double_click_ms = cfg_wdata[WIN_W-1:0];
        REG_LONG_PRESS_MS:   cfg_nxt.long_press_ms   = cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.active_high     <= 1'b0;
      cfg_r.bounce_ms       <= BOUNCE_MS_RST;
      cfg_r.double_click_ms <= DOUBLE_CLICK_MS_RST;
      cfg_r.long_press_ms   <= LONG_PRESS_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/bcgd_core.sv =====
// Debounce and gesture state of the button click gesture detector, with the
// next-state and result logic for one beat. Depends on bcgd_pkg.
module bcgd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bcgd_pkg::item_t   item,
  input  bcgd_pkg::cfg_t    cfg,
  output bcgd_pkg::result_t res
);
  import bcgd_pkg::*;

  logic              deb_pressed_r,  deb_pressed_nxt;
  logic              changed_r,      changed_nxt;
  logic              click_r,        click_nxt;
  logic              dbl_click_r,    dbl_click_nxt;
  logic              long_press_r,   long_press_nxt;
  logic              edge_handled_r, edge_handled_nxt;
  logic [TIME_W-1:0] last_change_r,  last_change_nxt;
  logic [TIME_W-1:0] last_click_r,   last_click_nxt;

  logic              pressed_now;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_click;
  logic              in_bounce;
  logic              in_dbl_window;
  logic              past_long;

  // Elapsed times wrap modulo 2^32; the windows are zero-extended.
  assign pressed_now   = (item.pin_level == cfg.active_high);
  assign since_change  = item.now_ms - last_change_r;
  assign since_click   = item.now_ms - last_click_r;
  assign in_bounce     = since_change < {{(TIME_W-WIN_W){1'b0}}, cfg.bounce_ms};
  assign in_dbl_window = since_click < {{(TIME_W-WIN_W){1'b0}}, cfg.double_click_ms};
  assign past_long     = since_change > {{(TIME_W-WIN_W){1'b0}}, cfg.long_press_ms};

  // Next state for the item on hand.
  always_comb begin
    deb_pressed_nxt  = deb_pressed_r;
    changed_nxt      = changed_r;
    click_nxt        = click_r;
    dbl_click_nxt    = dbl_click_r;
    long_press_nxt   = long_press_r;
    edge_handled_nxt = edge_handled_r;
    last_change_nxt  = last_change_r;
    last_click_nxt   = last_click_r;
    if (!cfg.enabled) begin
      deb_pressed_nxt  = 1'b0;
      changed_nxt      = 1'b0;
      click_nxt        = 1'b0;
      dbl_click_nxt    = 1'b0;
      long_press_nxt   = 1'b0;
      edge_handled_nxt = 1'b0;
      last_change_nxt  = '0;
      last_click_nxt   = '0;
    end else if ((item.kind == KIND_POLL) && edge_handled_r) begin
      // A poll straight after a handled edge is skipped.
      edge_handled_nxt = 1'b0;
    end else if (!in_bounce) begin
      changed_nxt      = 1'b0;
      click_nxt        = 1'b0;
      dbl_click_nxt    = 1'b0;
      edge_handled_nxt = item.kind;
      if (pressed_now != deb_pressed_r) begin
        deb_pressed_nxt = pressed_now;
        if (!pressed_now && long_press_r) begin
          // The release after a long press is swallowed.
          long_press_nxt = 1'b0;
        end else begin
          changed_nxt     = 1'b1;
          last_change_nxt = item.now_ms;
          if (!pressed_now) begin
            if (in_dbl_window) begin
              dbl_click_nxt = 1'b1;
            end else begin
              click_nxt      = 1'b1;
              last_click_nxt = item.now_ms;
            end
          end
        end
      end else if (pressed_now && past_long && !long_press_r) begin
        long_press_nxt = 1'b1;
        changed_nxt    = 1'b1;
      end
    end
  end

  // Result codes follow the updated flags.
  always_comb begin
    res.level_pressed = cfg.enabled && pressed_now;
    res.change_code   = CHG_NONE;
    res.action_code   = ACT_NONE;
    if (cfg.enabled && changed_nxt) begin
      res.change_code = deb_pressed_nxt ? CHG_PRESSED : CHG_RELEASED;
      if (long_press_nxt) begin
        res.action_code = ACT_LONG_PRESS;
      end else if (click_nxt) begin
        res.action_code = ACT_CLICK;
      end else if (dbl_click_nxt) begin
        res.action_code = ACT_DOUBLE_CLICK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_pressed_r  <= 1'b0;
      changed_r      <= 1'b0;
      click_r        <= 1'b0;
      dbl_click_r    <= 1'b0;
      long_press_r   <= 1'b0;
      edge_handled_r <= 1'b0;
      last_change_r  <= '0;
      last_click_r   <= '0;
    end else if (step) begin
      deb_pressed_r  <= deb_pressed_nxt;
      changed_r      <= changed_nxt;
      click_r        <= click_nxt;
      dbl_click_r    <= dbl_click_nxt;
      long_press_r   <= long_press_nxt;
      edge_handled_r <= edge_handled_nxt;
      last_change_r  <= last_change_nxt;
      last_click_r   <= last_click_nxt;
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the button click gesture detector.
// Depends on bcgd_pkg and button_click_gesture_detector; it predicts every
// result beat in step with the input and compares each field as it leaves.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bcgd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic                  in_kind           = KIND_POLL;
  logic                  in_pin_level      = 1'b0;
  logic [TIME_W-1:0]     in_now_ms         = '0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic                  out_level_pressed;
  logic [CODE_W-1:0]     out_change_code;
  logic [CODE_W-1:0]     out_action_code;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  // Results predicted for accepted beats, oldest first.
  result_t expected_results[$];
  int      errors     = 0;
  int      cycles     = 0;
  int      stall_left = 0;
  bit      idle_on    = 1'b1;
  bit      steady     = 1'b0;

  // Predictor copy of the registers.
  bit          m_enabled;
  bit          m_active_high;
  bit [15:0]   m_bounce;
  bit [15:0]   m_double;
  bit [15:0]   m_long;

  // Predictor copy of the gesture state.
  bit          held;
  bit          changed;
  bit          clicked;
  bit          dbl_clicked;
  bit          long_held;
  bit          edge_seen;
  bit [31:0]   change_t;
  bit [31:0]   click_t;

  button_click_gesture_detector DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_pin_level      (in_pin_level),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level_pressed (out_level_pressed),
    .out_change_code   (out_change_code),
    .out_action_code   (out_action_code),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("button_click_gesture_detector: mismatch");
      $finish;
    end
  end

  function automatic void clear_gesture();
    held        = 1'b0;
    changed     = 1'b0;
    clicked     = 1'b0;
    dbl_clicked = 1'b0;
    long_held   = 1'b0;
    edge_seen   = 1'b0;
    change_t    = '0;
    click_t     = '0;
  endfunction

  // Works out the result beat of one input beat and advances the gesture state.
  function automatic result_t predict_gesture(input bit kind, input bit pin,
                                              input bit [31:0] now);
    result_t   r;
    bit        pressed;
    bit        report;
    bit [31:0] since_change;
    bit [31:0] since_click;
    r = '0;
    if (!m_enabled) begin
      clear_gesture();
      return r;
    end
    pressed      = (pin == m_active_high);
    since_change = now - change_t;
    since_click  = now - click_t;
    if (kind == KIND_POLL && edge_seen) begin
      // A poll straight after a handled edge is skipped once.
      edge_seen = 1'b0;
    end else if (since_change < {16'b0, m_bounce}) begin
      // Still inside the bounce window: the held flags are repeated.
    end else begin
      changed     = 1'b0;
      clicked     = 1'b0;
      dbl_clicked = 1'b0;
      edge_seen   = (kind != KIND_POLL);
      if (pressed != held) begin
        report = 1'b1;
        if (!pressed) begin
          if (long_held) begin
            // The release that ends a long press is swallowed.
            long_held = 1'b0;
            report    = 1'b0;
          end else if (since_click < {16'b0, m_double}) begin
            dbl_clicked = 1'b1;
          end else begin
            clicked = 1'b1;
            click_t = now;
          end
        end
        held    = pressed;
        changed = report;
        if (report) begin
          change_t = now;
        end
      end else if (pressed && since_change > {16'b0, m_long} && !long_held) begin
        long_held = 1'b1;
        changed   = 1'b1;
      end
    end
    r.level_pressed = pressed;
    if (changed) begin
      r.change_code = held ? CHG_PRESSED : CHG_RELEASED;
      if (long_held) begin
        r.action_code = ACT_LONG_PRESS;
      end else if (clicked) begin
        r.action_code = ACT_CLICK;
      end else if (dbl_clicked) begin
        r.action_code = ACT_DOUBLE_CLICK;
      end else begin
        r.action_code = ACT_NONE;
      end
    end else begin
      r.change_code = CHG_NONE;
      r.action_code = ACT_NONE;
    end
    return r;
  endfunction

  // Random receiver stalls in bursts, only while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [CODE_W-1:0] want,
                             input logic [CODE_W-1:0] got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Each result beat is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: level %0d change %0d action %0d",
                 $time, out_level_pressed, out_change_code, out_action_code);
      end else begin
        want = expected_results.pop_front();
        check_field("level_pressed", {1'b0, want.level_pressed}, {1'b0, out_level_pressed});
        check_field("change_code", want.change_code, out_change_code);
        check_field("action_code", want.action_code, out_action_code);
      end
    end
  end

  // Offers one beat, at times with a random gap first, and records its prediction.
  task automatic send_item(input bit kind, input bit pin, input bit [31:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_pin_level <= pin;
    in_now_ms    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_gesture(kind, pin, now));
  endtask

  // Stops sending and waits until every predicted beat has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLED:         m_enabled     = data[0];
      REG_ACTIVE_HIGH:     m_active_high = data[0];
      REG_BOUNCE_MS:       m_bounce      = data;
      REG_DOUBLE_CLICK_MS: m_double      = data;
      REG_LONG_PRESS_MS:   m_long        = data;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_windows(input bit [15:0] bounce, input bit [15:0] dbl,
                             input bit [15:0] hold);
    write_reg(REG_BOUNCE_MS, bounce);
    write_reg(REG_DOUBLE_CLICK_MS, dbl);
    write_reg(REG_LONG_PRESS_MS, hold);
  endtask

  // Press, bounce, click, double click, skipped poll and long press with the
  // reset windows and a low-active pin.
  task automatic test_basic_gestures();
    write_reg(REG_ENABLED, 16'd1);
    send_item(KIND_EDGE, 1'b1, 32'd1000);
    send_item(KIND_POLL, 1'b1, 32'd1001);
    send_item(KIND_EDGE, 1'b0, 32'd1100);
    send_item(KIND_EDGE, 1'b1, 32'd1149);
    send_item(KIND_EDGE, 1'b1, 32'd1150);
    send_item(KIND_EDGE, 1'b0, 32'd1200);
    send_item(KIND_EDGE, 1'b1, 32'd1449);
    send_item(KIND_POLL, 1'b0, 32'd1500);
    send_item(KIND_POLL, 1'b0, 32'd1600);
    send_item(KIND_POLL, 1'b0, 32'd2600);
    send_item(KIND_POLL, 1'b0, 32'd2601);
    send_item(KIND_POLL, 1'b0, 32'd2700);
    send_item(KIND_POLL, 1'b1, 32'd2800);
  endtask

  // Time differences that wrap through zero, and both ends of the time range.
  task automatic test_wraparound();
    send_item(KIND_EDGE, 1'b0, 32'hFFFF_FFC0);
    send_item(KIND_EDGE, 1'b1, 32'h0000_0010);
    send_item(KIND_EDGE, 1'b0, 32'hFFFF_FFFF);
    send_item(KIND_POLL, 1'b1, 32'h0000_0000);
    settle();
  endtask

  task automatic test_active_high();
    write_reg(REG_ACTIVE_HIGH, 16'd1);
    send_item(KIND_EDGE, 1'b1, 32'd5000);
    send_item(KIND_POLL, 1'b1, 32'd5001);
    send_item(KIND_EDGE, 1'b0, 32'd5100);
    settle();
  endtask

  // Masked writes, writes to indexes past the last register, and disabling.
  task automatic test_register_edges();
    write_reg(REG_ENABLED, 16'hFFFE);
    send_item(KIND_EDGE, 1'b1, 32'd6000);
    send_item(KIND_POLL, 1'b0, 32'd6100);
    settle();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h0000);
    write_reg(REG_ACTIVE_HIGH, 16'hFFFE);
    write_reg(REG_ENABLED, 16'hFFFF);
    send_item(KIND_EDGE, 1'b0, 32'd7000);
    send_item(KIND_EDGE, 1'b1, 32'd7049);
    send_item(KIND_EDGE, 1'b1, 32'd7050);
    settle();
  endtask

  // Mostly well-formed press and release sequences with time steps chosen
  // around the current windows, plus some wild jumps in time.
  task automatic test_random_gestures(input int count);
    bit [31:0] t;
    bit [31:0] step;
    bit        pin;
    bit        kind;
    int        sel;
    t   = $urandom;
    pin = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        idle_on = !steady && ($urandom_range(0, 3) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        step = $urandom_range(0, m_bounce);
      end else if (sel < 24) begin
        case ($urandom_range(0, 5))
          0: step = {16'b0, m_bounce} - 1;
          1: step = {16'b0, m_bounce};
          2: step = {16'b0, m_double} - 1;
          3: step = {16'b0, m_double};
          4: step = {16'b0, m_long};
          default: step = {16'b0, m_long} + 1;
        endcase
      end else if (sel < 55) begin
        step = {16'b0, m_bounce} + $urandom_range(1, 40);
      end else if (sel < 80) begin
        step = $urandom_range(0, m_double);
      end else if (sel < 94) begin
        step = {16'b0, m_long} + $urandom_range(0, 8) - 4;
      end else begin
        step = $urandom;
      end
      t = t + step;
      if ($urandom_range(0, 99) < 45) begin
        pin = !pin;
      end
      kind = ($urandom_range(0, 1) != 0) ? KIND_EDGE : KIND_POLL;
      send_item(kind, pin, t);
      // A poll often lands right behind an edge event.
      if (kind == KIND_EDGE && $urandom_range(0, 3) == 0) begin
        send_item(KIND_POLL, pin, t + $urandom_range(0, 2));
      end
    end
    settle();
  endtask

  task automatic test_random_settings();
    write_reg(REG_ACTIVE_HIGH, 16'd0);
    test_random_gestures(220);
    write_reg(REG_ACTIVE_HIGH, 16'd1);
    set_windows(16'd5, 16'd120, 16'd300);
    test_random_gestures(220);
    set_windows(16'd0, 16'd0, 16'd0);
    test_random_gestures(140);
    set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_gestures(140);
    write_reg(REG_ACTIVE_HIGH, 16'd0);
    set_windows(16'd0, 16'hFFFF, 16'd20);
    test_random_gestures(140);
    set_windows(16'($urandom_range(0, 40)), 16'($urandom_range(60, 600)),
                16'($urandom_range(50, 2000)));
    test_random_gestures(180);
    write_reg(REG_ENABLED, 16'd0);
    test_random_gestures(60);
    write_reg(REG_ENABLED, 16'd1);
  endtask

  // Back-to-back beats with no gaps and no stalls.
  task automatic test_steady_stream();
    steady  = 1'b1;
    idle_on = 1'b0;
    set_windows(BOUNCE_MS_RST, DOUBLE_CLICK_MS_RST, LONG_PRESS_MS_RST);
    test_random_gestures(300);
  endtask

  initial begin
    m_enabled     = 1'b0;
    m_active_high = 1'b0;
    m_bounce      = BOUNCE_MS_RST;
    m_double      = DOUBLE_CLICK_MS_RST;
    m_long        = LONG_PRESS_MS_RST;
    clear_gesture();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_gestures();
    test_wraparound();
    test_active_high();
    test_register_edges();
    test_random_settings();
    test_steady_stream();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("button_click_gesture_detector: match");
    end else begin
      $display("button_click_gesture_detector: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bcgd_pkg.sv
hw/rtl/bcgd_cfg.sv
hw/rtl/bcgd_core.sv
hw/rtl/button_click_gesture_detector.sv
sim/testbench.sv
